// ----- hw/rtl/rtpr_pkg.sv -----
package rtpr_pkg;

  // slot index carried with a parsed packet, wide enough for a buffer of up to 32 slots
  localparam int IDX_W = 5;

  localparam logic [7:0]  VER_MASK  = 8'b1100_0000;
  localparam logic [7:0]  VER_RTP   = 8'b1000_0000;
  localparam logic [7:0]  CSRC_MASK = 8'b0000_1111;
  localparam logic [7:0]  EXT_FLAG  = 8'b0001_0000;
  localparam logic [13:0] HDR_BYTES = 14'd12;

  typedef struct packed {
    logic [7:0]  first_byte;
    logic [15:0] seq_num;
    logic [15:0] ext_words;
    logic [13:0] packet_len;
    logic [15:0] payload_handle;
  } pkt_t;

  typedef struct packed {
    logic [15:0] out_handle;
    logic [13:0] out_len;
    logic [15:0] out_seq;
    logic        last;
  } rel_t;

  typedef struct packed {
    logic [15:0]      seq;
    logic [IDX_W-1:0] idx;
    logic [13:0]      len;
    logic [15:0]      handle;
  } parsed_t;

endpackage

// ----- hw/rtl/rtp_reorder_buffer.sv -----
// path: parse, fold and push states for header parse and slot index, then classify,
// a scan per released packet and a flush to mark the last, plus the result queue
// throughput: the parser is busy until it returns to idle; the scan takes one slot
// per cycle while the result queue has room, up to REORDER_DEPTH per packet
// reset: synchronous, clears expected number, slot count, all slots and both queues
module rtp_reorder_buffer #(
  parameter int REORDER_DEPTH    = 6,
  parameter int MAX_PACKET_BYTES = 8192
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  rtpr_pkg::pkt_t  pkt,
  output logic            empty,
  input  logic            pop,
  output rtpr_pkg::rel_t  rel
);

  localparam int MID_W = $bits(rtpr_pkg::parsed_t);
  localparam int REL_W = $bits(rtpr_pkg::rel_t);

  logic              mid_push;
  logic              mid_full;
  rtpr_pkg::parsed_t mid_wdata;
  logic              mid_pop;
  logic              mid_empty;
  rtpr_pkg::parsed_t mid_rdata;
  logic              out_push;
  logic              out_full;
  rtpr_pkg::rel_t    out_data;

  rtpr_front #(
    .DEPTH     (REORDER_DEPTH),
    .MAX_BYTES (MAX_PACKET_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .pkt      (pkt),
    .mid_push (mid_push),
    .mid_full (mid_full),
    .mid_data (mid_wdata)
  );

  rtpr_fifo #(
    .WIDTH (MID_W)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .full  (mid_full),
    .wdata (mid_wdata),
    .pop   (mid_pop),
    .empty (mid_empty),
    .rdata (mid_rdata)
  );

  rtpr_back #(
    .DEPTH (REORDER_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_item  (mid_rdata),
    .in_empty (mid_empty),
    .in_pop   (mid_pop),
    .out_push (out_push),
    .out_full (out_full),
    .out_data (out_data)
  );

  rtpr_fifo #(
    .WIDTH (REL_W)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .full  (out_full),
    .wdata (out_data),
    .pop   (pop),
    .empty (empty),
    .rdata (rel)
  );

  a_mid_no_overflow: assert property (@(posedge clk) disable iff (rst)
    mid_push |-> !mid_full)
    else $error("parsed packet pushed into a full queue");

  a_out_no_overflow: assert property (@(posedge clk) disable iff (rst)
    out_push |-> !out_full)
    else $error("release pushed into a full result queue");

  a_mid_no_underflow: assert property (@(posedge clk) disable iff (rst)
    mid_pop |-> !mid_empty)
    else $error("classifier took from an empty queue");

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> full)
    else $error("parser not busy after taking a request");

endmodule

// ----- hw/rtl/rtpr_fifo.sv -----
module rtpr_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// ----- hw/rtl/rtpr_front.sv -----
module rtpr_front #(
  parameter int DEPTH     = 6,
  parameter int MAX_BYTES = 8192
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  rtpr_pkg::pkt_t     pkt,
  output logic               mid_push,
  input  logic               mid_full,
  output rtpr_pkg::parsed_t  mid_data
);

  localparam int KB      = $clog2(DEPTH);
  localparam int SH      = 16 + KB;
  localparam int RECIP_I = ((1 << SH) + DEPTH - 1) / DEPTH;
  localparam int QW      = 17 + KB;
  localparam logic [SH:0]    RECIP    = RECIP_I[SH:0];
  localparam logic [QW-1:0]  DEPTH_Q  = DEPTH[QW-1:0];
  localparam logic [16:0]    DEPTH_17 = DEPTH[16:0];
  localparam logic [16:0]    MAX_17   = MAX_BYTES[16:0];
  localparam logic [13:0]    MAX_14   = MAX_BYTES[13:0];

  typedef enum logic [3:0] {
    F_IDLE  = 4'b0001,
    F_PARSE = 4'b0010,
    F_FOLD  = 4'b0100,
    F_PUSH  = 4'b1000
  } fstate_t;

  fstate_t        state;
  rtpr_pkg::pkt_t raw;
  logic           ok;
  logic [13:0]    len;
  logic [SH+16:0] prod;
  logic [QW-1:0]  qd;

  logic [13:0] plen_c;
  logic        hdr_ok;
  logic [13:0] body;
  logic [7:0]  csrc_m;
  logic [18:0] ext_bytes;
  logic [18:0] skip;
  logic        ok_c;
  logic [13:0] len_c;
  logic [16:0] rem;
  logic [16:0] rem_fix;

  always_comb begin
    plen_c = ({3'b000, raw.packet_len} > MAX_17) ? MAX_14 : raw.packet_len;
    hdr_ok = (plen_c > rtpr_pkg::HDR_BYTES) &&
             ((raw.first_byte & rtpr_pkg::VER_MASK) == rtpr_pkg::VER_RTP);
    body   = plen_c - rtpr_pkg::HDR_BYTES;
    csrc_m = raw.first_byte & rtpr_pkg::CSRC_MASK;
    if ((raw.first_byte & rtpr_pkg::EXT_FLAG) != 8'd0) begin
      ext_bytes = {1'b0, raw.ext_words, 2'b00} + 19'd4;
    end else begin
      ext_bytes = 19'd0;
    end
    skip  = {9'd0, csrc_m, 2'b00} + ext_bytes;
    ok_c  = hdr_ok && (skip <= {5'd0, body});
    len_c = body - skip[13:0];
  end

  // seq mod depth by reciprocal multiply, then one correction step
  always_comb begin
    rem     = {1'b0, raw.seq_num} - qd[16:0];
    rem_fix = (rem >= DEPTH_17) ? rem - DEPTH_17 : rem;
  end

  assign full     = (state != F_IDLE);
  assign mid_push = (state == F_PUSH) && ok && !mid_full;

  always_comb begin
    mid_data        = '0;
    mid_data.seq    = raw.seq_num;
    mid_data.idx    = rem_fix[rtpr_pkg::IDX_W-1:0];
    mid_data.len    = len;
    mid_data.handle = raw.payload_handle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (push) begin
            state <= F_PARSE;
          end
        end
        F_PARSE: state <= F_FOLD;
        F_FOLD:  state <= F_PUSH;
        F_PUSH: begin
          if (!ok || !mid_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && push) begin
      raw <= pkt;
    end
    if (state == F_PARSE) begin
      ok   <= ok_c;
      len  <= len_c;
      prod <= {{(SH + 1){1'b0}}, raw.seq_num} * {16'd0, RECIP};
    end
    if (state == F_FOLD) begin
      qd <= {{(KB + 1){1'b0}}, prod[SH +: 16]} * DEPTH_Q;
    end
  end

endmodule

// ----- hw/rtl/rtpr_back.sv -----
module rtpr_back #(
  parameter int DEPTH = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  rtpr_pkg::parsed_t in_item,
  input  logic              in_empty,
  output logic              in_pop,
  output logic              out_push,
  input  logic              out_full,
  output rtpr_pkg::rel_t    out_data
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int TWO_D_I = 2 * DEPTH;
  localparam int NEG_TWO_D_I = 65536 - 2 * DEPTH;
  localparam logic [15:0]   D_LIM     = DEPTH[15:0];
  localparam logic [15:0]   TWO_D     = TWO_D_I[15:0];
  localparam logic [15:0]   NEG_TWO_D = NEG_TWO_D_I[15:0];
  localparam logic [IW-1:0] LAST_IDX  = IW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_MAX   = CW'(DEPTH);

  typedef enum logic [2:0] {
    B_IDLE  = 3'b001,
    B_SCAN  = 3'b010,
    B_FLUSH = 3'b100
  } bstate_t;

  function automatic logic [IW-1:0] inc_idx(input logic [IW-1:0] i);
    inc_idx = (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  // slot index of s+1, restarting at zero when the sequence number wraps
  function automatic logic [IW-1:0] step_idx(input logic [15:0] s, input logic [IW-1:0] i);
    step_idx = (s == 16'hFFFF) ? '0 : inc_idx(i);
  endfunction

  bstate_t           state;
  logic [15:0]       expected;
  logic [IW-1:0]     exp_idx;
  logic [7:0]        used;
  logic [CW-1:0]     cnt;
  logic              gap_mode;
  logic              pend_valid;
  rtpr_pkg::rel_t    pend;
  rtpr_pkg::parsed_t held;

  logic [15:0] slot_seq    [DEPTH];
  logic [13:0] slot_len    [DEPTH];
  logic [15:0] slot_handle [DEPTH];

  logic [15:0]       seq_dist;
  logic              resync;
  logic              is_exact;
  logic              is_past;
  logic              is_gap;
  logic              hit;
  logic              gap_match;
  logic              park_en;
  rtpr_pkg::parsed_t park_src;
  logic [IW-1:0]     park_idx;
  logic [7:0]        used_inc;

  always_comb begin
    seq_dist = in_item.seq - expected;
    resync   = seq_dist[15] ? (seq_dist < NEG_TWO_D) : (seq_dist > TWO_D);
    is_exact = resync || (seq_dist == 16'd0);
    is_past  = seq_dist[15] && !resync;
    is_gap   = !seq_dist[15] && !resync && (seq_dist > D_LIM);
    hit       = (used != 8'd0) && (cnt < CNT_MAX) && (slot_seq[exp_idx] == expected);
    gap_match = gap_mode && (held.seq == expected);
    used_inc  = (used != 8'hFF) ? used + 8'd1 : used;
  end

  assign in_pop = (state == B_IDLE) && !in_empty;

  // parking happens either straight from the queue or after a gap scan
  always_comb begin
    park_en  = 1'b0;
    park_src = held;
    unique case (state)
      B_IDLE: begin
        park_src = in_item;
        park_en  = !in_empty && !is_exact && !is_past && !is_gap;
      end
      B_SCAN: park_en = !out_full && !hit && gap_mode && !gap_match;
      B_FLUSH: park_en = 1'b0;
      default: park_en = 1'b0;
    endcase
    park_idx = park_src.idx[IW-1:0];
  end

  always_comb begin
    out_push      = 1'b0;
    out_data      = pend;
    out_data.last = 1'b0;
    unique case (state)
      B_SCAN:  out_push = !out_full && pend_valid && (hit || gap_match);
      B_FLUSH: begin
        out_push      = !out_full && pend_valid;
        out_data.last = 1'b1;
      end
      B_IDLE:  out_push = 1'b0;
      default: out_push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      expected   <= 16'd0;
      exp_idx    <= '0;
      used       <= 8'd0;
      cnt        <= '0;
      gap_mode   <= 1'b0;
      pend_valid <= 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        slot_seq[i]    <= 16'd0;
        slot_len[i]    <= 14'd0;
        slot_handle[i] <= 16'd0;
      end
    end else begin
      if (park_en) begin
        slot_seq[park_idx]    <= park_src.seq;
        slot_len[park_idx]    <= park_src.len;
        slot_handle[park_idx] <= park_src.handle;
        used                  <= used_inc;
      end
      unique case (state)
        B_IDLE: begin
          if (!in_empty) begin
            cnt      <= '0;
            gap_mode <= 1'b0;
            held     <= in_item;
            if (is_exact) begin
              if (resync) begin
                used <= 8'd0;
              end
              pend.out_handle <= in_item.handle;
              pend.out_len    <= in_item.len;
              pend.out_seq    <= in_item.seq;
              pend.last       <= 1'b0;
              pend_valid      <= 1'b1;
              expected        <= in_item.seq + 16'd1;
              exp_idx         <= step_idx(in_item.seq, in_item.idx[IW-1:0]);
              state           <= B_SCAN;
            end else if (is_gap) begin
              // give up on one expected number, then scan
              gap_mode   <= 1'b1;
              pend_valid <= 1'b0;
              expected   <= expected + 16'd1;
              exp_idx    <= step_idx(expected, exp_idx);
              state      <= B_SCAN;
            end
          end
        end
        B_SCAN: begin
          if (!out_full) begin
            if (hit) begin
              pend.out_handle <= slot_handle[exp_idx];
              pend.out_len    <= slot_len[exp_idx];
              pend.out_seq    <= slot_seq[exp_idx];
              pend.last       <= 1'b0;
              pend_valid      <= 1'b1;
              expected        <= expected + 16'd1;
              exp_idx         <= step_idx(expected, exp_idx);
              used            <= used - 8'd1;
              cnt             <= cnt + 1'b1;
            end else begin
              if (gap_match) begin
                pend.out_handle <= held.handle;
                pend.out_len    <= held.len;
                pend.out_seq    <= held.seq;
                pend.last       <= 1'b0;
                pend_valid      <= 1'b1;
                expected        <= expected + 16'd1;
                exp_idx         <= step_idx(expected, exp_idx);
              end
              state <= B_FLUSH;
            end
          end
        end
        B_FLUSH: begin
          if (!pend_valid) begin
            state <= B_IDLE;
          end else if (!out_full) begin
            pend_valid <= 1'b0;
            state      <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/tb_rtp_reorder_buffer.sv -----
`timescale 1ns / 1ps

module tb_rtp_reorder_buffer;

  localparam int DEPTH        = 6;
  localparam int MAX_BYTES    = 8192;
  localparam int LEN_SAT      = 16383;
  localparam int IDLE_MAX     = 10;
  localparam int DRAIN_CYCLES = 40;

  logic clk  = 1'b0;
  logic rst  = 1'b1;
  logic push = 1'b0;
  logic pop  = 1'b0;
  rtpr_pkg::pkt_t pkt = '0;
  logic full;
  logic empty;
  rtpr_pkg::rel_t rel;

  rtp_reorder_buffer dut (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .pkt   (pkt),
    .empty (empty),
    .pop   (pop),
    .rel   (rel)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [15:0] want_seq = '0;
  logic [7:0]  park_cnt = '0;
  logic [15:0] park_seq    [DEPTH] = '{default: '0};
  logic [13:0] park_len    [DEPTH] = '{default: '0};
  logic [15:0] park_handle [DEPTH] = '{default: '0};

  rtpr_pkg::rel_t step_rel[$];
  rtpr_pkg::rel_t pending_rel[$];

  bit send_idle   = 1'b1;
  bit recv_idle   = 1'b1;
  int hold_cycles = 0;
  int n_req       = 0;
  int n_rel       = 0;
  int full_cycles = 0;
  int errors      = 0;

  always @(posedge clk) begin
    if (!rst && push && full) full_cycles++;
  end

  function automatic void emit_rel(input logic [15:0] h, input logic [13:0] l,
                                   input logic [15:0] s);
    rtpr_pkg::rel_t r;
    r.out_handle = h;
    r.out_len    = l;
    r.out_seq    = s;
    r.last       = 1'b0;
    step_rel.push_back(r);
  endfunction

  // release parked successors of the expected number
  function automatic void scan_parked();
    int idx;
    int lp;
    bit hit;
    hit = 1'b1;
    lp = 0;
    while (hit && park_cnt != 0 && lp < DEPTH) begin
      idx = want_seq % DEPTH;
      if (park_seq[idx] == want_seq) begin
        emit_rel(park_handle[idx], park_len[idx], park_seq[idx]);
        want_seq = want_seq + 16'd1;
        park_cnt = park_cnt - 8'd1;
        lp++;
      end else begin
        hit = 1'b0;
      end
    end
  endfunction

  function automatic void predict_release(input rtpr_pkg::pkt_t p);
    int plen;
    int pay;
    int skip_b;
    int seq_dist;
    int mag;
    int idx;
    logic [15:0] d;
    bit parked;
    rtpr_pkg::rel_t r;
    step_rel.delete();
    plen = p.packet_len;
    if (plen > MAX_BYTES) plen = MAX_BYTES;
    if (plen <= int'(rtpr_pkg::HDR_BYTES)) return;
    if ((p.first_byte & rtpr_pkg::VER_MASK) != rtpr_pkg::VER_RTP) return;
    pay = plen - int'(rtpr_pkg::HDR_BYTES);
    skip_b = 4 * int'(p.first_byte & rtpr_pkg::CSRC_MASK);
    if ((p.first_byte & rtpr_pkg::EXT_FLAG) != 0) skip_b += 4 * (1 + int'(p.ext_words));
    if (skip_b > pay) return;
    pay -= skip_b;
    if (pay > LEN_SAT) pay = LEN_SAT;

    d = p.seq_num - want_seq;
    seq_dist = $signed(d);
    mag = (seq_dist < 0) ? -seq_dist : seq_dist;
    if (mag > 2 * DEPTH) begin
      mag = 0;
      park_cnt = '0;
    end else if (seq_dist < 0) begin
      return;
    end

    if (mag == 0) begin
      emit_rel(p.payload_handle, 14'(pay), p.seq_num);
      want_seq = p.seq_num + 16'd1;
      scan_parked();
    end else begin
      parked = 1'b1;
      // moderate gap gives up on one expected number
      if (mag > DEPTH) begin
        want_seq = want_seq + 16'd1;
        scan_parked();
        if (p.seq_num == want_seq) begin
          emit_rel(p.payload_handle, 14'(pay), p.seq_num);
          want_seq = p.seq_num + 16'd1;
          parked = 1'b0;
        end
      end
      if (parked) begin
        idx = p.seq_num % DEPTH;
        if (park_cnt != 8'hFF) park_cnt = park_cnt + 8'd1;
        park_seq[idx]    = p.seq_num;
        park_len[idx]    = 14'(pay);
        park_handle[idx] = p.payload_handle;
      end
    end

    foreach (step_rel[i]) begin
      r = step_rel[i];
      r.last = (i == step_rel.size() - 1);
      pending_rel.push_back(r);
    end
    step_rel.delete();
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s expected %0d got %0d", name, want, got);
      errors++;
    end
  endfunction

  task automatic send_pkt(input rtpr_pkg::pkt_t p);
    int gap;
    gap = send_idle ? $urandom_range(0, IDLE_MAX) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    pkt  <= p;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_release(p);
    n_req++;
  endtask

  task automatic wait_drain();
    push <= 1'b0;
    while (pending_rel.size() != 0) @(posedge clk);
    // dropped or parked requests may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic rtpr_pkg::pkt_t mk_hdr(input logic [7:0] fb, input logic [15:0] seq,
                                            input logic [15:0] ext, input logic [13:0] len,
                                            input logic [15:0] h);
    rtpr_pkg::pkt_t p;
    p.first_byte     = fb;
    p.seq_num        = seq;
    p.ext_words      = ext;
    p.packet_len     = len;
    p.payload_handle = h;
    return p;
  endfunction

  // well-formed header with random csrc, extension, padding and length
  function automatic rtpr_pkg::pkt_t mk_pkt(input logic [15:0] seq);
    rtpr_pkg::pkt_t p;
    int skip_b;
    p.first_byte = rtpr_pkg::VER_RTP | (8'($urandom_range(0, 15)) & rtpr_pkg::CSRC_MASK);
    p.first_byte[5] = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 3) == 0) p.first_byte = p.first_byte | rtpr_pkg::EXT_FLAG;
    p.ext_words = ((p.first_byte & rtpr_pkg::EXT_FLAG) != 0) ? 16'($urandom_range(0, 40))
                                                             : 16'($urandom);
    skip_b = 4 * int'(p.first_byte & rtpr_pkg::CSRC_MASK);
    if ((p.first_byte & rtpr_pkg::EXT_FLAG) != 0) skip_b += 4 * (1 + int'(p.ext_words));
    case ($urandom_range(0, 15))
      0: p.packet_len = 14'(int'(rtpr_pkg::HDR_BYTES) + skip_b);
      1: p.packet_len = 14'($urandom_range(MAX_BYTES + 1, LEN_SAT));
      default: p.packet_len = 14'(int'(rtpr_pkg::HDR_BYTES) + skip_b +
                                  $urandom_range(1, 1400));
    endcase
    p.seq_num        = seq;
    p.payload_handle = 16'($urandom);
    return p;
  endfunction

  task automatic test_header_checks();
    send_pkt(mk_hdr(8'h40, 16'd0, 16'd0, 14'd100, 16'h0001));
    send_pkt(mk_hdr(8'hC0, 16'd0, 16'd0, 14'd100, 16'h0002));
    send_pkt(mk_hdr(8'h00, 16'd0, 16'd0, 14'd100, 16'h0003));
    send_pkt(mk_hdr(8'h80, 16'd0, 16'd0, 14'd12, 16'h0004));
    send_pkt(mk_hdr(8'h80, 16'd0, 16'd0, 14'd0, 16'h0005));
    // oversized length clamped, huge extension still too long
    send_pkt(mk_hdr(8'hBF, 16'd0, 16'hFFFF, 14'h3FFF, 16'hFFFF));
    send_pkt(mk_hdr(8'h8F, 16'd0, 16'd0, 14'd71, 16'h0006));
    // empty payload after all csrc words and extension
    send_pkt(mk_hdr(8'hBF, 16'd0, 16'd0, 14'd76, 16'h0000));
    send_pkt(mk_hdr(8'h80, 16'd1, 16'hFFFF, 14'd13, 16'hFFFF));
    send_pkt(mk_hdr(8'hA0, 16'd2, 16'd0, 14'h3FFF, 16'h5A5A));
    wait_drain();
  endtask

  task automatic test_release_order();
    int i;
    send_pkt(mk_pkt(16'd5));
    send_pkt(mk_pkt(16'd4));
    send_pkt(mk_pkt(16'd3));
    send_pkt(mk_pkt(16'd2));
    // fill every slot, then a moderate gap lets the scan catch up to the request
    for (i = 7; i <= 12; i++) send_pkt(mk_pkt(16'(i)));
    send_pkt(mk_pkt(16'd13));
    send_pkt(mk_pkt(16'd22));
    send_pkt(mk_pkt(16'hFFFE));
    send_pkt(mk_pkt(16'h0000));
    send_pkt(mk_pkt(16'hFFFF));
    wait_drain();
  endtask

  task automatic test_random_streams(input int n_items, input bit idle);
    int sent;
    int k;
    int j;
    int r;
    int lose;
    logic [15:0] win [DEPTH];
    logic [15:0] tmp;
    rtpr_pkg::pkt_t p;
    send_idle = idle;
    recv_idle = idle;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        // a short run of consecutive numbers in shuffled order, sometimes one lost
        k = $urandom_range(1, DEPTH);
        for (j = 0; j < k; j++) win[j] = want_seq + 16'(j);
        for (j = k - 1; j > 0; j--) begin
          r = $urandom_range(0, j);
          tmp = win[j];
          win[j] = win[r];
          win[r] = tmp;
        end
        lose = ($urandom_range(0, 4) == 0) ? $urandom_range(0, k - 1) : -1;
        for (j = 0; j < k; j++) begin
          if (j != lose) begin
            send_pkt(mk_pkt(win[j]));
            sent++;
          end
        end
      end else begin
        if (r < 70) begin
          p = mk_pkt(want_seq + 16'($urandom_range(DEPTH + 1, 2 * DEPTH)));
        end else if (r < 77) begin
          p = mk_pkt(want_seq + 16'($urandom_range(2 * DEPTH + 1, 65535 - 2 * DEPTH)));
        end else if (r < 85) begin
          p = mk_pkt(want_seq - 16'($urandom_range(1, 2 * DEPTH)));
        end else if (r < 93) begin
          p = mk_pkt(16'($urandom));
          case ($urandom_range(0, 2))
            0: begin
              do p.first_byte[7:6] = 2'($urandom_range(0, 3));
              while ((p.first_byte & rtpr_pkg::VER_MASK) == rtpr_pkg::VER_RTP);
            end
            1: p.packet_len = 14'($urandom_range(0, int'(rtpr_pkg::HDR_BYTES)));
            default: begin
              p.first_byte = p.first_byte | rtpr_pkg::CSRC_MASK;
              p.packet_len = 14'($urandom_range(13, 71));
            end
          endcase
        end else begin
          p.first_byte     = 8'($urandom);
          p.seq_num        = 16'($urandom);
          p.ext_words      = 16'($urandom);
          p.packet_len     = 14'($urandom);
          p.payload_handle = 16'($urandom);
        end
        send_pkt(p);
        sent++;
      end
    end
    wait_drain();
  endtask

  // park the same window over and over until the slot count saturates
  task automatic test_park_flood();
    logic [15:0] base;
    int i;
    send_idle = 1'b0;
    recv_idle = 1'b1;
    base = want_seq;
    for (i = 0; i < 257; i++) send_pkt(mk_pkt(base + 16'(1 + i % DEPTH)));
    send_pkt(mk_pkt(base));
    wait_drain();
  endtask

  task automatic test_backpressure();
    int i;
    send_idle = 1'b0;
    recv_idle = 1'b0;
    hold_cycles = 800;
    for (i = 0; i < 20; i++) send_pkt(mk_pkt(want_seq));
    wait_drain();
    recv_idle = 1'b1;
  endtask

  initial begin : rel_sink
    int gap;
    while (rst) @(posedge clk);
    forever begin
      gap = recv_idle ? $urandom_range(0, IDLE_MAX) : 0;
      gap += hold_cycles;
      hold_cycles = 0;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      n_rel++;
      if (pending_rel.size() == 0) begin
        $error("release with no request waiting: seq %0d", rel.out_seq);
        errors++;
      end else begin
        check_field("out_handle", pending_rel[0].out_handle, rel.out_handle);
        check_field("out_len", pending_rel[0].out_len, rel.out_len);
        check_field("out_seq", pending_rel[0].out_seq, rel.out_seq);
        check_field("last", pending_rel[0].last, rel.last);
        void'(pending_rel.pop_front());
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_header_checks();
    test_release_order();
    test_random_streams(20, 1'b1);
    test_random_streams(8, 1'b0);
    test_park_flood();
    test_backpressure();
    $display("%0d requests sent, %0d releases checked, input held by full for %0d cycles",
             n_req, n_rel, full_cycles);
    $display("header drops, reordered runs, gap skips, resyncs and a saturated slot count");
    if (errors == 0) begin
      $display("tb_rtp_reorder_buffer passed");
    end else begin
      $display("tb_rtp_reorder_buffer failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb_rtp_reorder_buffer failed");
    $finish;
  end

endmodule
